// ----- hdl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation codes, pipeline payload types and the saturation helpers
// shared by the stages of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SAT_W   = PROD_W + 1;
    localparam int SHIFT_W = DATA_W - FRAC_W;
    localparam int STEP_N  = DATA_W;
    localparam int SQR_W   = DATA_W + 4;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_NEG = 3'd4,
        FN_MAG = 3'd5,
        FN_EQ  = 3'd6
    } t_func;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     eq;
        logic                     dz;
        logic                     ov;
    } t_res;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ov;
    } t_part;

    // Payload of the quotient and square root step chain.
    typedef struct packed {
        logic              vld;
        t_func             func;
        t_res              res;
        logic              neg_re;
        logic              neg_im;
        logic              big_re;
        logic              big_im;
        logic [PROD_W-1:0] rem_re;
        logic [PROD_W-1:0] rem_im;
        logic [PROD_W-1:0] den;
        logic [PROD_W-1:0] sq_src;
        logic [DATA_W-1:0] xlo_re;
        logic [DATA_W-1:0] xlo_im;
        logic [DATA_W-1:0] q_re;
        logic [DATA_W-1:0] q_im;
        logic [DATA_W-1:0] root;
        logic [SQR_W-1:0]  sq_rem;
    } t_iter;

    // Clamp a sign and magnitude value to the signed data range.
    function automatic t_part f_sat(input logic neg, input logic [SAT_W-1:0] mag);
        logic [SAT_W-1:0]  lim;
        logic [SAT_W-1:0]  m;
        logic [DATA_W-1:0] mt;
        t_part             r;
        lim   = neg ? (SAT_W'(1) << (DATA_W - 1))
                    : ((SAT_W'(1) << (DATA_W - 1)) - SAT_W'(1));
        r.ov  = mag > lim;
        m     = r.ov ? lim : mag;
        mt    = m[DATA_W-1:0];
        r.val = neg ? (~mt + 1'b1) : mt;
        return r;
    endfunction

    // Clamp a two's complement value two bits wider than the data range.
    function automatic t_part f_clamp(input logic signed [DATA_W+1:0] v);
        t_part r;
        r.ov = !((v[DATA_W+1:DATA_W-1] == 3'b000) || (v[DATA_W+1:DATA_W-1] == 3'b111));
        if (r.ov) begin
            r.val = v[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/cau_in_if.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit input channel
// Valid/ready channel carrying the operation code and the two operands.
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       func;
    logic signed [cau_pkg::DATA_W-1:0] a_re;
    logic signed [cau_pkg::DATA_W-1:0] a_im;
    logic signed [cau_pkg::DATA_W-1:0] b_re;
    logic signed [cau_pkg::DATA_W-1:0] b_im;

    modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
    modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

// ----- hdl/cau_out_if.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit output channel
// Valid/ready channel carrying the result parts and the status flags.
// ----------------------------------------------------------------------------
interface cau_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [cau_pkg::DATA_W-1:0] res_re;
    logic signed [cau_pkg::DATA_W-1:0] res_im;
    logic                             equal;
    logic                             div_zero;
    logic                             overflow;

    modport source(output valid, res_re, res_im, equal, div_zero, overflow, input ready);
    modport sink(input valid, res_re, res_im, equal, div_zero, overflow, output ready);
endinterface

// ----- hdl/cau_front.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Four stages: products and short operations, sums, magnitudes, then
// product rounding and set-up of the quotient and root step chain.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    cau_in_if.sink         i_in,
    output cau_pkg::t_iter o_q
);

    typedef struct packed {
        logic                              vld;
        cau_pkg::t_func                    func;
        logic signed [cau_pkg::PROD_W-1:0] p_rr;
        logic signed [cau_pkg::PROD_W-1:0] p_ii;
        logic signed [cau_pkg::PROD_W-1:0] p_ri;
        logic signed [cau_pkg::PROD_W-1:0] p_ir;
        logic [cau_pkg::PROD_W-1:0]        sq0;
        logic [cau_pkg::PROD_W-1:0]        sq1;
        cau_pkg::t_res                     res;
    } t_st1;

    typedef struct packed {
        logic                             vld;
        cau_pkg::t_func                   func;
        logic signed [cau_pkg::SUM_W-1:0] sum_re;
        logic signed [cau_pkg::SUM_W-1:0] sum_im;
        logic [cau_pkg::PROD_W-1:0]       sq_sum;
        cau_pkg::t_res                    res;
    } t_st2;

    typedef struct packed {
        logic                       vld;
        cau_pkg::t_func             func;
        logic                       neg_re;
        logic                       neg_im;
        logic [cau_pkg::PROD_W-1:0] mag_re;
        logic [cau_pkg::PROD_W-1:0] mag_im;
        logic [cau_pkg::PROD_W-1:0] sq_sum;
        logic                       dz;
        cau_pkg::t_res              res;
    } t_st3;

    t_st1           r_s1, n_s1;
    t_st2           r_s2, n_s2;
    t_st3           r_s3, n_s3;
    cau_pkg::t_iter r_s4, n_s4;

    logic signed [cau_pkg::DATA_W+1:0] x_a;
    logic signed [cau_pkg::DATA_W+1:0] x_ai;
    logic signed [cau_pkg::DATA_W+1:0] x_b;
    logic signed [cau_pkg::DATA_W+1:0] x_bi;
    logic signed [cau_pkg::DATA_W-1:0] x_sq0;
    logic signed [cau_pkg::DATA_W-1:0] x_sq1;
    logic signed [cau_pkg::PROD_W-1:0] x_p0;
    logic signed [cau_pkg::PROD_W-1:0] x_p1;
    cau_pkg::t_part                    x_cre;
    cau_pkg::t_part                    x_cim;
    logic signed [cau_pkg::SUM_W-1:0]  x_abs_re;
    logic signed [cau_pkg::SUM_W-1:0]  x_abs_im;
    logic [cau_pkg::SAT_W-1:0]         x_rnd_re;
    logic [cau_pkg::SAT_W-1:0]         x_rnd_im;
    cau_pkg::t_part                    x_mre;
    cau_pkg::t_part                    x_mim;

    // Stage 1: the four cross products, two squares and the short operations.
    always_comb begin
        x_a   = (cau_pkg::DATA_W+2)'(i_in.a_re);
        x_ai  = (cau_pkg::DATA_W+2)'(i_in.a_im);
        x_b   = (cau_pkg::DATA_W+2)'(i_in.b_re);
        x_bi  = (cau_pkg::DATA_W+2)'(i_in.b_im);
        n_s1.vld  = i_in.valid;
        n_s1.func = cau_pkg::t_func'(i_in.func);
        n_s1.p_rr = cau_pkg::PROD_W'(i_in.a_re) * cau_pkg::PROD_W'(i_in.b_re);
        n_s1.p_ii = cau_pkg::PROD_W'(i_in.a_im) * cau_pkg::PROD_W'(i_in.b_im);
        n_s1.p_ri = cau_pkg::PROD_W'(i_in.a_re) * cau_pkg::PROD_W'(i_in.b_im);
        n_s1.p_ir = cau_pkg::PROD_W'(i_in.a_im) * cau_pkg::PROD_W'(i_in.b_re);
        // Magnitude squares the first operand, division the second.
        x_sq0 = (n_s1.func == cau_pkg::FN_MAG) ? i_in.a_re : i_in.b_re;
        x_sq1 = (n_s1.func == cau_pkg::FN_MAG) ? i_in.a_im : i_in.b_im;
        x_p0  = cau_pkg::PROD_W'(x_sq0) * cau_pkg::PROD_W'(x_sq0);
        x_p1  = cau_pkg::PROD_W'(x_sq1) * cau_pkg::PROD_W'(x_sq1);
        n_s1.sq0 = x_p0;
        n_s1.sq1 = x_p1;
        n_s1.res = '0;
        x_cre = '0;
        x_cim = '0;
        case (n_s1.func)
            cau_pkg::FN_ADD: begin
                x_cre = cau_pkg::f_clamp(x_a + x_b);
                x_cim = cau_pkg::f_clamp(x_ai + x_bi);
            end
            cau_pkg::FN_SUB: begin
                x_cre = cau_pkg::f_clamp(x_a - x_b);
                x_cim = cau_pkg::f_clamp(x_ai - x_bi);
            end
            cau_pkg::FN_NEG: begin
                x_cre = cau_pkg::f_clamp(-x_a);
                x_cim = cau_pkg::f_clamp(-x_ai);
            end
            cau_pkg::FN_EQ: begin
                n_s1.res.eq = (i_in.a_re == i_in.b_re) && (i_in.a_im == i_in.b_im);
            end
            default: begin
                x_cre = '0;
            end
        endcase
        n_s1.res.re = x_cre.val;
        n_s1.res.im = x_cim.val;
        n_s1.res.ov = x_cre.ov | x_cim.ov;
    end

    // Stage 2: product sums; division takes the conjugate of the divisor.
    always_comb begin
        n_s2.vld  = r_s1.vld;
        n_s2.func = r_s1.func;
        n_s2.res  = r_s1.res;
        if (r_s1.func == cau_pkg::FN_DIV) begin
            n_s2.sum_re = cau_pkg::SUM_W'(r_s1.p_rr) + cau_pkg::SUM_W'(r_s1.p_ii);
            n_s2.sum_im = cau_pkg::SUM_W'(r_s1.p_ir) - cau_pkg::SUM_W'(r_s1.p_ri);
        end else begin
            n_s2.sum_re = cau_pkg::SUM_W'(r_s1.p_rr) - cau_pkg::SUM_W'(r_s1.p_ii);
            n_s2.sum_im = cau_pkg::SUM_W'(r_s1.p_ri) + cau_pkg::SUM_W'(r_s1.p_ir);
        end
        n_s2.sq_sum = r_s1.sq0 + r_s1.sq1;
    end

    // Stage 3: sign and magnitude of both sums.
    always_comb begin
        x_abs_re    = r_s2.sum_re[cau_pkg::SUM_W-1] ? -r_s2.sum_re : r_s2.sum_re;
        x_abs_im    = r_s2.sum_im[cau_pkg::SUM_W-1] ? -r_s2.sum_im : r_s2.sum_im;
        n_s3.vld    = r_s2.vld;
        n_s3.func   = r_s2.func;
        n_s3.res    = r_s2.res;
        n_s3.neg_re = r_s2.sum_re[cau_pkg::SUM_W-1];
        n_s3.neg_im = r_s2.sum_im[cau_pkg::SUM_W-1];
        n_s3.mag_re = x_abs_re[cau_pkg::PROD_W-1:0];
        n_s3.mag_im = x_abs_im[cau_pkg::PROD_W-1:0];
        n_s3.sq_sum = r_s2.sq_sum;
        n_s3.dz     = (r_s2.func == cau_pkg::FN_DIV) && (r_s2.sq_sum == '0);
    end

    // Stage 4: round the product, load the quotient and root chain.
    always_comb begin
        x_rnd_re = (cau_pkg::SAT_W'(r_s3.mag_re) + (cau_pkg::SAT_W'(1) << (cau_pkg::FRAC_W - 1)))
                   >> cau_pkg::FRAC_W;
        x_rnd_im = (cau_pkg::SAT_W'(r_s3.mag_im) + (cau_pkg::SAT_W'(1) << (cau_pkg::FRAC_W - 1)))
                   >> cau_pkg::FRAC_W;
        x_mre    = cau_pkg::f_sat(r_s3.neg_re, x_rnd_re);
        x_mim    = cau_pkg::f_sat(r_s3.neg_im, x_rnd_im);
        n_s4        = '0;
        n_s4.vld    = r_s3.vld;
        n_s4.func   = r_s3.func;
        n_s4.res    = r_s3.res;
        n_s4.res.dz = r_s3.dz;
        if (r_s3.func == cau_pkg::FN_MUL) begin
            n_s4.res.re = x_mre.val;
            n_s4.res.im = x_mim.val;
            n_s4.res.ov = x_mre.ov | x_mim.ov;
        end
        n_s4.neg_re = r_s3.neg_re;
        n_s4.neg_im = r_s3.neg_im;
        // A quotient of more than DATA_W bits is saturated without being formed.
        n_s4.big_re = (cau_pkg::PROD_W+cau_pkg::SHIFT_W)'(r_s3.mag_re)
                      >= {r_s3.sq_sum, {cau_pkg::SHIFT_W{1'b0}}};
        n_s4.big_im = (cau_pkg::PROD_W+cau_pkg::SHIFT_W)'(r_s3.mag_im)
                      >= {r_s3.sq_sum, {cau_pkg::SHIFT_W{1'b0}}};
        n_s4.rem_re = r_s3.mag_re >> cau_pkg::SHIFT_W;
        n_s4.rem_im = r_s3.mag_im >> cau_pkg::SHIFT_W;
        n_s4.xlo_re = cau_pkg::DATA_W'(r_s3.mag_re << cau_pkg::FRAC_W);
        n_s4.xlo_im = cau_pkg::DATA_W'(r_s3.mag_im << cau_pkg::FRAC_W);
        n_s4.den    = r_s3.sq_sum;
        n_s4.sq_src = r_s3.sq_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_q = r_s4;

endmodule

// ----- hdl/cau_step.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit step stage
// One registered step: a restoring quotient bit for each part and one bit
// of the integer square root.
// ----------------------------------------------------------------------------
module cau_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cau_pkg::t_iter i_d,
    output cau_pkg::t_iter o_q
);

    cau_pkg::t_iter             r_q, n_q;
    logic [cau_pkg::PROD_W-1:0] x_sh_re;
    logic [cau_pkg::PROD_W-1:0] x_sh_im;
    logic                       x_ge_re;
    logic                       x_ge_im;
    logic [cau_pkg::SQR_W-1:0]  x_sh_sq;
    logic [cau_pkg::SQR_W-1:0]  x_trial;
    logic                       x_ge_sq;

    always_comb begin
        // The remainder stays below the divisor, so its top bit is free.
        x_sh_re = {i_d.rem_re[cau_pkg::PROD_W-2:0], i_d.xlo_re[cau_pkg::DATA_W-1]};
        x_sh_im = {i_d.rem_im[cau_pkg::PROD_W-2:0], i_d.xlo_im[cau_pkg::DATA_W-1]};
        x_ge_re = x_sh_re >= i_d.den;
        x_ge_im = x_sh_im >= i_d.den;
        x_sh_sq = {i_d.sq_rem[cau_pkg::SQR_W-3:0],
                   i_d.sq_src[cau_pkg::PROD_W-1:cau_pkg::PROD_W-2]};
        x_trial = cau_pkg::SQR_W'({i_d.root, 2'b01});
        x_ge_sq = x_sh_sq >= x_trial;

        n_q        = i_d;
        n_q.rem_re = x_ge_re ? (x_sh_re - i_d.den) : x_sh_re;
        n_q.rem_im = x_ge_im ? (x_sh_im - i_d.den) : x_sh_im;
        n_q.xlo_re = i_d.xlo_re << 1;
        n_q.xlo_im = i_d.xlo_im << 1;
        n_q.q_re   = {i_d.q_re[cau_pkg::DATA_W-2:0], x_ge_re};
        n_q.q_im   = {i_d.q_im[cau_pkg::DATA_W-2:0], x_ge_im};
        n_q.sq_rem = x_ge_sq ? (x_sh_sq - x_trial) : x_sh_sq;
        n_q.sq_src = i_d.sq_src << 2;
        n_q.root   = {i_d.root[cau_pkg::DATA_W-2:0], x_ge_sq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- hdl/cau_back.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Final saturation of quotient and root, result selection and the output
// register that drives the result channel.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cau_pkg::t_iter i_d,
    output logic           o_en,
    cau_out_if.source      o_out
);

    logic           r_vld;
    cau_pkg::t_res  r_res, n_res;
    cau_pkg::t_part x_qre;
    cau_pkg::t_part x_qim;
    cau_pkg::t_part x_root;

    always_comb begin
        x_qre  = cau_pkg::f_sat(i_d.neg_re, cau_pkg::SAT_W'({i_d.big_re, i_d.q_re}));
        x_qim  = cau_pkg::f_sat(i_d.neg_im, cau_pkg::SAT_W'({i_d.big_im, i_d.q_im}));
        x_root = cau_pkg::f_sat(1'b0, cau_pkg::SAT_W'(i_d.root));
        n_res  = i_d.res;
        case (i_d.func)
            cau_pkg::FN_DIV: begin
                n_res = '0;
                if (i_d.res.dz) begin
                    n_res.dz = 1'b1;
                end else begin
                    n_res.re = x_qre.val;
                    n_res.im = x_qim.val;
                    n_res.ov = x_qre.ov | x_qim.ov;
                end
            end
            cau_pkg::FN_MAG: begin
                n_res    = '0;
                n_res.re = x_root.val;
                n_res.ov = x_root.ov;
            end
            default: begin
                n_res = i_d.res;
            end
        endcase
    end

    // The whole pipeline advances whenever the output register can take an item.
    assign o_en = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_en) begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid    = r_vld;
    assign o_out.res_re   = r_res.re;
    assign o_out.res_im   = r_res.im;
    assign o_out.equal    = r_res.eq;
    assign o_out.div_zero = r_res.dz;
    assign o_out.overflow = r_res.ov;

endmodule

// ----- hdl/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, negate, magnitude and equality test on
// two complex Q16.16 operands. The unit takes one item every cycle while
// the output is not stalled. Each result passes through four front stages
// (products, sums, magnitudes, rounding and set-up), a chain of 32 stages
// that each form one quotient bit of both parts and one bit of the square
// root, and the output register. A stall on the result side holds every
// stage in place. Results outside the Q16.16 range saturate and set
// overflow; a zero divisor gives a zero result with div_zero set.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);

    logic           w_en;
    cau_pkg::t_iter w_chain [cau_pkg::STEP_N+1];

    assign i_in.ready = w_en;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_in    (i_in),
        .o_q     (w_chain[0])
    );

    for (genvar g = 0; g < cau_pkg::STEP_N; g++) begin : g_step
        cau_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_chain[cau_pkg::STEP_N]),
        .o_en    (w_en),
        .o_out   (o_out)
    );

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[cau_pkg::STEP_N].vld && (w_chain[cau_pkg::STEP_N].func == cau_pkg::FN_MAG)
        |-> (w_chain[cau_pkg::STEP_N].sq_src == '0))
        else $error("square root radicand not fully consumed");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[cau_pkg::STEP_N].vld && (w_chain[cau_pkg::STEP_N].func == cau_pkg::FN_DIV)
        && !w_chain[cau_pkg::STEP_N].res.dz && !w_chain[cau_pkg::STEP_N].big_re
        |-> (w_chain[cau_pkg::STEP_N].rem_re < w_chain[cau_pkg::STEP_N].den))
        else $error("division remainder not below divisor");

    a_dz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.div_zero
        |-> (o_out.res_re == '0) && (o_out.res_im == '0) && !o_out.overflow && !o_out.equal)
        else $error("zero divisor result not cleared");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_chain[cau_pkg::STEP_N]))
        else $error("pipeline moved during a stall");

endmodule

// ----- test/tb_cau_chan_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The channels of the unit are the interfaces of the design itself; this
// file only holds the small package of testbench item types.
// ----------------------------------------------------------------------------
package tb_cau_types_pkg;

    import cau_pkg::*;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } t_op_item;

endpackage

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives operation items through the valid/ready input channel, predicts
// each result with an independent fixed-point model unless its row gives
// one, and compares every result field in order. Sender and receiver idle
// at random in three phases; one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb;

    import cau_pkg::*;
    import tb_cau_types_pkg::*;

    localparam int  N_RANDOM  = 1330;
    localparam int  LATENCY   = 37;
    localparam longint LIMIT  = 400000;
    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cau_in_if  in_ch();
    cau_out_if out_ch();

    complex_arithmetic_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_res    expected_q[$];
    int      n_errors = 0;
    int      n_results = 0;
    int      n_sent = 0;
    longint  cycle = 0;
    int      send_idle_pct = 33;
    int      recv_idle_pct = 65;
    logic    hold_off = 1'b0;
    logic    done_sending = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h want %h", n_results, what, got, want);
        n_errors++;
    endtask

    // Sign-magnitude clamp to the 32-bit range; a 160-bit magnitude is ample.
    function automatic logic [31:0] clamp_part(input logic neg, input logic [159:0] mag,
                                               inout logic ov);
        logic [159:0] lim;
        lim = neg ? 160'h80000000 : 160'h7fffffff;
        if (mag > lim) begin
            ov  = 1'b1;
            mag = lim;
        end
        return neg ? 32'(-mag) : mag[31:0];
    endfunction

    function automatic t_res predict_cplx(input t_op_item it);
        logic signed [159:0] ar, ai, br, bi, pr, pi, den, nr, ni, s, qr, qi, mr, mi;
        logic [159:0]        root, t;
        t_res r;
        ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
        r = '0;
        pr = 0; pi = 0;
        case (it.func)
            FN_ADD: begin pr = ar + br; pi = ai + bi; end
            FN_SUB: begin pr = ar - br; pi = ai - bi; end
            FN_NEG: begin pr = -ar; pi = -ai; end
            FN_MUL: begin
                nr = ar * br - ai * bi;
                ni = ar * bi + ai * br;
                mr = nr < 0 ? -nr : nr;
                mi = ni < 0 ? -ni : ni;
                mr = (mr + (1 << (FRAC_W - 1))) >>> FRAC_W;
                mi = (mi + (1 << (FRAC_W - 1))) >>> FRAC_W;
                pr = nr < 0 ? -mr : mr;
                pi = ni < 0 ? -mi : mi;
            end
            FN_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    nr = (ar * br + ai * bi) <<< FRAC_W;
                    ni = (ai * br - ar * bi) <<< FRAC_W;
                    qr = (nr < 0 ? -nr : nr) / den;
                    qi = (ni < 0 ? -ni : ni) / den;
                    pr = nr < 0 ? -qr : qr;
                    pi = ni < 0 ? -qi : qi;
                end
            end
            FN_MAG: begin
                s = ar * ar + ai * ai;
                root = 0;
                for (int k = 63; k >= 0; k--) begin
                    t = root | (160'd1 << k);
                    if (t * t <= s) root = t;
                end
                pr = root;
            end
            FN_EQ: r.eq = (it.a_re == it.b_re) && (it.a_im == it.b_im);
            default: ;
        endcase
        if (it.func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_NEG, FN_MAG} && !r.dz) begin
            r.re = clamp_part(pr < 0, pr < 0 ? -pr : pr, r.ov);
            r.im = clamp_part(pi < 0, pi < 0 ? -pi : pi, r.ov);
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 9))
            0: return MAXV;
            1: return MINV;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3: return 32'($signed($urandom_range(0, 65535 * 8)) - 65535 * 4);
            4: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'h007fffff);
            default: return $urandom();
        endcase
    endfunction

    // Directed rows; a typed-in expectation is used when has_want is set.
    typedef struct {
        t_op_item op;
        logic     has_want;
        t_res     want;
    } t_row;

    t_row rows[$];
    t_op_item stim_q[$];
    t_res     want_q[$];

    task automatic add_row(input logic [2:0] f, input logic [31:0] a0, input logic [31:0] a1,
                           input logic [31:0] b0, input logic [31:0] b1,
                           input logic hw, input t_res w);
        t_row r;
        r.op = '{f, a0, a1, b0, b1};
        r.has_want = hw;
        r.want = w;
        rows.push_back(r);
    endtask

    initial begin
        t_op_item it;
        int       n_idle;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.a_re = '0; in_ch.a_im = '0; in_ch.b_re = '0; in_ch.b_im = '0;

        add_row(FN_ADD, MAXV, MINV, 1, 32'hffffffff, 1, '{MAXV, MINV, 0, 0, 1});
        add_row(FN_ADD, 32'h10000, 32'h20000, 32'h30000, 32'hfffc0000, 1,
                '{32'h40000, 32'hfffe0000, 0, 0, 0});
        add_row(FN_SUB, MINV, MAXV, 1, 32'hffffffff, 1, '{MINV, MAXV, 0, 0, 1});
        add_row(FN_SUB, 5, 7, 5, 7, 1, '{0, 0, 0, 0, 0});
        add_row(FN_MUL, 32'h10000, 32'h0, 32'h18000, 32'h8000, 0, '0);
        add_row(FN_MUL, MAXV, MAXV, MAXV, MAXV, 0, '0);
        add_row(FN_MUL, MINV, MINV, MINV, MINV, 0, '0);
        add_row(FN_MUL, 1, 1, 32'h8000, 0, 0, '0);
        add_row(FN_MUL, 32'hffffffff, 0, 32'h8000, 0, 0, '0);
        add_row(FN_DIV, 32'h10000, 32'h10000, 0, 0, 1, '{0, 0, 0, 1, 0});
        add_row(FN_DIV, MAXV, MINV, 0, 0, 1, '{0, 0, 0, 1, 0});
        add_row(FN_DIV, 32'h30000, 32'h10000, 32'h10000, 32'h10000, 0, '0);
        add_row(FN_DIV, MAXV, MAXV, 1, 0, 0, '0);
        add_row(FN_DIV, MINV, MINV, MINV, MINV, 0, '0);
        add_row(FN_DIV, 7, 3, 32'hfffffffd, 11, 0, '0);
        add_row(FN_NEG, MINV, 5, 0, 0, 1, '{MAXV, 32'hfffffffb, 0, 0, 1});
        add_row(FN_NEG, MAXV, 0, 0, 0, 1, '{32'h80000001, 0, 0, 0, 0});
        add_row(FN_MAG, 32'h30000, 32'h40000, 0, 0, 1, '{32'h50000, 0, 0, 0, 0});
        add_row(FN_MAG, MINV, MINV, 0, 0, 1, '{MAXV, 0, 0, 0, 1});
        add_row(FN_MAG, 2, 0, 0, 0, 0, '0);
        add_row(FN_EQ, 123, MINV, 123, MINV, 1, '{0, 0, 1, 0, 0});
        add_row(FN_EQ, 123, MINV, 123, MAXV, 1, '{0, 0, 0, 0, 0});
        add_row(3'd7, MAXV, MAXV, 0, 0, 1, '0);

        foreach (rows[k]) begin
            stim_q.push_back(rows[k].op);
            want_q.push_back(rows[k].has_want ? rows[k].want : predict_cplx(rows[k].op));
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            it.func = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            it.a_re = rand_part(); it.a_im = rand_part();
            it.b_re = rand_part(); it.b_im = rand_part();
            if (it.func == FN_EQ && $urandom_range(0, 1)) begin
                it.b_re = it.a_re;
                it.b_im = ($urandom_range(0, 2) == 0) ? it.a_im ^ (32'd1 << $urandom_range(0, 31))
                                                      : it.a_im;
            end
            if (it.func == FN_DIV && $urandom_range(0, 9) == 0) begin
                it.b_re = 0; it.b_im = 0;
            end
            stim_q.push_back(it);
            want_q.push_back(predict_cplx(it));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_q[k]) begin
            if (k == 450) begin
                send_idle_pct = 65; recv_idle_pct = 33;
            end else if (k == 900) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            n_idle = 0;
            while ($urandom_range(0, 99) < send_idle_pct) n_idle++;
            // Valid drops only for the cycles in which the sender idles.
            if (n_idle != 0) begin
                in_ch.valid <= 1'b0;
                repeat (n_idle) @(posedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.func  <= stim_q[k].func;
            in_ch.a_re  <= stim_q[k].a_re;
            in_ch.a_im  <= stim_q[k].a_im;
            in_ch.b_re  <= stim_q[k].b_re;
            in_ch.b_im  <= stim_q[k].b_im;
            expected_q.push_back(want_q[k]);
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            n_sent++;
        end
        in_ch.valid <= 1'b0;
        done_sending = 1'b1;
    end

    // Long receiver hold-off once the pipeline has items in flight.
    initial begin
        wait (n_sent == 1000);
        hold_off = 1'b1;
        for (int c = 0; c < 120; c++) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 64'(out_ch.res_re), 64'd0);
            end else begin
                w = expected_q.pop_front();
                if (out_ch.res_re !== w.re) report("res_re", out_ch.res_re, w.re);
                if (out_ch.res_im !== w.im) report("res_im", out_ch.res_im, w.im);
                if (out_ch.equal !== w.eq) report("equal", out_ch.equal, w.eq);
                if (out_ch.div_zero !== w.dz) report("div_zero", out_ch.div_zero, w.dz);
                if (out_ch.overflow !== w.ov) report("overflow", out_ch.overflow, w.ov);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle,
                     expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        wait (done_sending);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_q.size() != 0) n_errors++;
        $display("checked %0d results over all seven operations and the unused code,",
                 n_results);
        $display("with saturation, zero divisors and three idling phases; %0d mismatches",
                 n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
